// ===== hw/rtl/upc_pkg.sv =====
package upc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ClassW = 6;
  localparam int unsigned CntW   = 2;

  // configuration register indexes
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_KIND      = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [KindW-1:0] KIND_USER  = 2'd0;
  localparam logic [KindW-1:0] KIND_PATH  = 2'd1;
  localparam logic [KindW-1:0] KIND_KEY   = 2'd2;
  localparam logic [KindW-1:0] KIND_VALUE = 2'd3;

  localparam logic [ClassW-1:0] MASK_USER  = 6'h05;
  localparam logic [ClassW-1:0] MASK_PATH  = 6'h0F;
  localparam logic [ClassW-1:0] MASK_QUERY = 6'h1F;

  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_PCT   = 8'h25;
  localparam logic [ByteW-1:0] CH_AMP   = 8'h26;
  localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2F;
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;
  localparam logic [ByteW-1:0] CH_EQ    = 8'h3D;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;
  localparam logic [ByteW-1:0] CH_UC_A  = 8'h41;
  localparam logic [ByteW-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [ByteW-1:0] LC_OFS   = 8'h20;
  localparam logic [ByteW-1:0] HEX_ALPHA_OFS = 8'h37; // 'A' - 10
  localparam logic [ByteW-1:0] LC_DIGIT_OFS  = 8'h57; // 'a' - 10

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upc_phase_e;

  typedef struct packed {
    upc_phase_e       phase;
    logic [ByteW-1:0] held;
  } upc_state_t;

  // up to three result bytes, sent b0 first
  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } upc_res_t;

  function automatic logic [ClassW-1:0] char_class(input logic [ByteW-1:0] b);
    logic [ClassW-1:0] c;
    case (b) inside
      8'h21, 8'h24, [8'h26:8'h2E], [8'h30:8'h39], 8'h3B, 8'h3D,
      [8'h41:8'h5A], 8'h5F, [8'h61:8'h7A], 8'h7E: c = 6'h01;
      8'h25:   c = 6'h20;
      8'h2F:   c = 6'h08;
      8'h3A:   c = 6'h04;
      8'h3F:   c = 6'h10;
      8'h40:   c = 6'h02;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

  function automatic logic must_encode(input logic [ByteW-1:0] b,
                                       input logic [KindW-1:0] kind);
    logic [ClassW-1:0] c;
    logic              m;
    c = char_class(b);
    case (kind)
      KIND_USER:  m = (c & MASK_USER) == '0;
      KIND_PATH:  m = ((c & MASK_PATH) == '0) || (b == CH_SLASH);
      KIND_KEY:   m = (b == CH_PLUS) || (b == CH_EQ) || (b == CH_AMP) ||
                      (b == CH_SEMI) || ((c & MASK_QUERY) == '0);
      default:    m = (b == CH_PLUS) || (b == CH_AMP) || (b == CH_SEMI) ||
                      ((c & MASK_QUERY) == '0);
    endcase
    return m;
  endfunction

  function automatic logic [ByteW-1:0] hex_up(input logic [3:0] v);
    logic [ByteW-1:0] w;
    w = {4'h0, v};
    return (v < 4'd10) ? CH_ZERO + w : HEX_ALPHA_OFS + w;
  endfunction

  // no validation: non-digits fold onto the lowercase-letter offset
  function automatic logic [ByteW-1:0] digit_value(input logic [ByteW-1:0] d);
    logic [ByteW-1:0] x;
    x = d;
    if (d >= CH_ZERO && d <= CH_NINE) begin
      return d - CH_ZERO;
    end
    if (d >= CH_UC_A && d <= CH_UC_Z) begin
      x = d + LC_OFS;
    end
    return x - LC_DIGIT_OFS;
  endfunction

endpackage

// ===== hw/rtl/upc_xlate.sv =====
module upc_xlate (
  input  logic [upc_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  input  logic                      dir_i,
  input  logic [upc_pkg::KindW-1:0] kind_i,
  input  upc_pkg::upc_state_t       state_i,
  output upc_pkg::upc_res_t         res_o,
  output upc_pkg::upc_state_t       state_o
);

  logic                      query;
  logic [upc_pkg::ByteW-1:0] plain;
  logic [upc_pkg::ByteW-1:0] hi_val;
  logic [upc_pkg::ByteW-1:0] lo_val;
  logic [upc_pkg::ByteW-1:0] esc_val;

  assign query  = kind_i[1];
  assign plain  = (query && byte_i == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : byte_i;
  assign hi_val = upc_pkg::digit_value(state_i.held);
  assign lo_val = upc_pkg::digit_value(byte_i);
  assign esc_val = {hi_val[3:0], 4'h0} | lo_val;

  always_comb begin
    res_o   = '{cnt: 2'd0, b0: byte_i, b1: byte_i, b2: byte_i};
    state_o = state_i;
    if (dir_i == upc_pkg::DIR_ENCODE) begin
      state_o = '{phase: upc_pkg::PH_IDLE, held: '0};
      if (query && byte_i == upc_pkg::CH_SPACE) begin
        res_o.cnt = 2'd1;
        res_o.b0  = upc_pkg::CH_PLUS;
      end else if (upc_pkg::must_encode(byte_i, kind_i)) begin
        res_o.cnt = 2'd3;
        res_o.b0  = upc_pkg::CH_PCT;
        res_o.b1  = upc_pkg::hex_up(byte_i[7:4]);
        res_o.b2  = upc_pkg::hex_up(byte_i[3:0]);
      end else begin
        res_o.cnt = 2'd1;
      end
    end else begin
      case (state_i.phase)
        upc_pkg::PH_PCT: begin
          if (last_i) begin
            // escape cut short: literal '%' then the byte as a plain char
            res_o.cnt = 2'd2;
            res_o.b0  = upc_pkg::CH_PCT;
            res_o.b1  = plain;
            state_o.phase = upc_pkg::PH_IDLE;
          end else begin
            state_o.held  = byte_i;
            state_o.phase = upc_pkg::PH_DIGIT;
          end
        end
        upc_pkg::PH_DIGIT: begin
          res_o.cnt = 2'd1;
          res_o.b0  = esc_val;
          state_o.phase = upc_pkg::PH_IDLE;
        end
        default: begin
          state_o.phase = upc_pkg::PH_IDLE;
          if (byte_i == upc_pkg::CH_PCT && !last_i) begin
            state_o.phase = upc_pkg::PH_PCT;
          end else begin
            res_o.cnt = 2'd1;
            res_o.b0  = plain;
          end
        end
      endcase
    end
    if (last_i) begin
      state_o.phase = upc_pkg::PH_IDLE;
    end
  end

endmodule

// ===== hw/rtl/url_percent_codec.sv =====
// URL percent encoder / decoder, one byte per transfer.
// Input channel: in_valid_i / in_stall_o with in_byte_i and in_last_i (end of
// string). Output channel: out_valid_o / out_stall_i with out_byte_o,
// item_done_o (last byte caused by one input byte) and string_done_o (last byte
// of the string). Config: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 direction, 1 component kind); write only while the block is idle.
// An accepted byte sits in an input register, is converted combinationally into
// a result buffer of up to three bytes; the first result is valid once it is
// registered there. The buffer sends one byte per cycle while the output is not
// stalled, so the rate is one input byte per cycle for single-byte results. A
// '%' or first hex digit while decoding produces no output unless it ends the
// string. The input register takes a new byte while results are still waiting.
// Stalling the output holds the current byte; the input stalls once the input
// register is full and cannot move on.
// Reset clears the config (encode, user info), any pending escape and all
// buffered data.
module url_percent_codec (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [1:0]                cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [upc_pkg::ByteW-1:0] in_byte_i,
  input  logic                      in_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [upc_pkg::ByteW-1:0] out_byte_o,
  output logic                      item_done_o,
  output logic                      string_done_o
);

  logic                      dir_q;
  logic [upc_pkg::KindW-1:0] kind_q;

  logic                      in_vld_q;
  logic [upc_pkg::ByteW-1:0] in_byte_q;
  logic                      in_last_q;

  upc_pkg::upc_state_t st_q, st_d;
  upc_pkg::upc_res_t   res_q, res_d, res_new;
  logic                res_last_q;

  logic out_xfer;
  logic buf_free;
  logic move;
  logic in_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;
  assign buf_free = (res_q.cnt == 2'd0) || (res_q.cnt == 2'd1 && out_xfer);
  assign move     = in_vld_q && buf_free;
  assign in_stall_o = in_vld_q && !buf_free;
  assign in_xfer  = in_valid_i && !in_stall_o;

  upc_xlate u_xlate (
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .dir_i   (dir_q),
    .kind_i  (kind_q),
    .state_i (st_q),
    .res_o   (res_new),
    .state_o (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= upc_pkg::DIR_ENCODE;
      kind_q <= upc_pkg::KIND_USER;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        upc_pkg::REG_DIRECTION: dir_q  <= cfg_wdata_i[0];
        upc_pkg::REG_KIND:      kind_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  always_comb begin
    res_d = res_q;
    if (move) begin
      res_d = res_new;
    end else if (out_xfer) begin
      res_d.cnt = res_q.cnt - 2'd1;
      res_d.b0  = res_q.b1;
      res_d.b1  = res_q.b2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '{phase: upc_pkg::PH_IDLE, held: '0};
      res_q      <= '0;
      res_last_q <= 1'b0;
    end else begin
      res_q <= res_d;
      if (move) begin
        st_q       <= st_d;
        res_last_q <= in_last_q;
      end
    end
  end

  assign out_valid_o   = res_q.cnt != 2'd0;
  assign out_byte_o    = res_q.b0;
  assign item_done_o   = res_q.cnt == 2'd1;
  assign string_done_o = item_done_o && res_last_q;

  a_str_done_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    string_done_o |-> item_done_o && out_valid_o)
    else $error("string_done without item_done");

  a_last_clears_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && in_last_q) |=> st_q.phase == upc_pkg::PH_IDLE)
    else $error("escape still pending after end of string");

  a_encode_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && dir_q == upc_pkg::DIR_ENCODE) |=>
      st_q.phase == upc_pkg::PH_IDLE && st_q.held == '0)
    else $error("encode left decode state behind");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !item_done_o) |=> out_valid_o)
    else $error("buffered result lost");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int ItemTarget = 170;
  localparam int SettleCyc  = 6;

  typedef struct packed {
    logic                      is_cfg;
    logic                      idx;
    logic [1:0]                val;
    logic [upc_pkg::ByteW-1:0] b;
    logic                      last;
  } feed_t;

  typedef struct packed {
    logic [upc_pkg::ByteW-1:0] b;
    logic                      item_done;
    logic                      string_done;
  } conv_byte_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_index_i = 1'b0;
  logic [1:0]                cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [upc_pkg::ByteW-1:0] in_byte_i = '0;
  logic                      in_last_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [upc_pkg::ByteW-1:0] out_byte_o;
  logic                      item_done_o;
  logic                      string_done_o;

  feed_t      feed_q[$];
  conv_byte_t expected_bytes[$];
  int         n_fed = 0;
  int         mismatches = 0;
  bit         feed_done = 1'b0;
  logic       in_fire = 1'b0;
  int         gap_left = 0;
  int         calm_left = 0;
  int         quiet = 0;
  int         stall_left = 0;
  int         open_left = 0;

  // predictor copy of the block's config and escape state
  logic                      cfg_dir = upc_pkg::DIR_ENCODE;
  logic [upc_pkg::KindW-1:0] cfg_kind = upc_pkg::KIND_USER;
  upc_pkg::upc_phase_e       esc_phase = upc_pkg::PH_IDLE;
  logic [upc_pkg::ByteW-1:0] esc_held = '0;

  url_percent_codec DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .item_done_o   (item_done_o),
    .string_done_o (string_done_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [upc_pkg::ClassW-1:0] url_class(
      input logic [upc_pkg::ByteW-1:0] b);
    if (b == upc_pkg::CH_PCT) return 6'h20;
    if (b == upc_pkg::CH_SLASH) return 6'h08;
    if (b == 8'h3A) return 6'h04;  // ':'
    if (b == 8'h3F) return 6'h10;  // '?'
    if (b == 8'h40) return 6'h02;  // '@'
    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
        (b >= 8'h61 && b <= 8'h7A)) return 6'h01;
    if (b == 8'h21 || b == 8'h24 || (b >= 8'h26 && b <= 8'h2E) ||
        b == upc_pkg::CH_SEMI || b == upc_pkg::CH_EQ || b == 8'h5F ||
        b == 8'h7E) return 6'h01;
    return 6'h00;
  endfunction

  function automatic logic needs_escape(input logic [upc_pkg::ByteW-1:0] b,
                                        input logic [upc_pkg::KindW-1:0] kind);
    logic [upc_pkg::ClassW-1:0] c;
    c = url_class(b);
    case (kind)
      upc_pkg::KIND_USER: return (c & upc_pkg::MASK_USER) == '0;
      upc_pkg::KIND_PATH: return (c & upc_pkg::MASK_PATH) == '0 ||
                                 b == upc_pkg::CH_SLASH;
      upc_pkg::KIND_KEY:  return b == upc_pkg::CH_PLUS || b == upc_pkg::CH_EQ ||
                                 b == upc_pkg::CH_AMP || b == upc_pkg::CH_SEMI ||
                                 (c & upc_pkg::MASK_QUERY) == '0;
      default:            return b == upc_pkg::CH_PLUS || b == upc_pkg::CH_AMP ||
                                 b == upc_pkg::CH_SEMI ||
                                 (c & upc_pkg::MASK_QUERY) == '0;
    endcase
  endfunction

  function automatic logic [upc_pkg::ByteW-1:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h41 + {4'h0, v} - 8'd10;
  endfunction

  // unvalidated: anything outside '0'..'9' is taken relative to 'a' - 10
  function automatic logic [upc_pkg::ByteW-1:0] nibble_of(
      input logic [upc_pkg::ByteW-1:0] d);
    logic [upc_pkg::ByteW-1:0] x;
    x = d;
    if (d >= 8'h30 && d <= 8'h39) return d - 8'h30;
    if (d >= 8'h41 && d <= 8'h5A) x = d + 8'h20;
    return x - 8'h57;
  endfunction

  function automatic logic [upc_pkg::ByteW-1:0] plain_dec(
      input logic [upc_pkg::ByteW-1:0] b);
    return (cfg_kind[1] && b == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : b;
  endfunction

  task automatic predict_codec(input logic [upc_pkg::ByteW-1:0] b, input logic last);
    logic [upc_pkg::ByteW-1:0] outs[$];
    logic [upc_pkg::ByteW-1:0] hi;
    conv_byte_t                r;
    if (cfg_dir == upc_pkg::DIR_ENCODE) begin
      esc_phase = upc_pkg::PH_IDLE;
      esc_held  = '0;
      if (cfg_kind[1] && b == upc_pkg::CH_SPACE) begin
        outs.push_back(upc_pkg::CH_PLUS);
      end else if (needs_escape(b, cfg_kind)) begin
        outs.push_back(upc_pkg::CH_PCT);
        outs.push_back(hex_char(b[7:4]));
        outs.push_back(hex_char(b[3:0]));
      end else begin
        outs.push_back(b);
      end
    end else begin
      case (esc_phase)
        upc_pkg::PH_PCT: begin
          if (last) begin
            // escape cut short: '%' then the byte as ordinary text
            outs.push_back(upc_pkg::CH_PCT);
            outs.push_back(plain_dec(b));
            esc_phase = upc_pkg::PH_IDLE;
          end else begin
            esc_held  = b;
            esc_phase = upc_pkg::PH_DIGIT;
          end
        end
        upc_pkg::PH_DIGIT: begin
          hi = nibble_of(esc_held);
          outs.push_back({hi[3:0], 4'h0} | nibble_of(b));
          esc_phase = upc_pkg::PH_IDLE;
        end
        default: begin
          esc_phase = upc_pkg::PH_IDLE;
          if (b == upc_pkg::CH_PCT && !last) esc_phase = upc_pkg::PH_PCT;
          else if (b == upc_pkg::CH_PCT) outs.push_back(upc_pkg::CH_PCT);
          else outs.push_back(plain_dec(b));
        end
      endcase
    end
    if (last) esc_phase = upc_pkg::PH_IDLE;
    foreach (outs[i]) begin
      r.b           = outs[i];
      r.item_done   = (i == outs.size() - 1);
      r.string_done = r.item_done && last;
      expected_bytes.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  task automatic add_cfg(input logic idx, input logic [1:0] val);
    feed_t f;
    f        = '0;
    f.is_cfg = 1'b1;
    f.idx    = idx;
    f.val    = val;
    feed_q.push_back(f);
  endtask

  task automatic add_byte(input logic [upc_pkg::ByteW-1:0] b, input logic last);
    feed_t f;
    f      = '0;
    f.b    = b;
    f.last = last;
    feed_q.push_back(f);
    n_fed++;
  endtask

  function automatic logic [upc_pkg::ByteW-1:0] pick_digit();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, v} - 8'd10;
  endfunction

  task automatic add_enc_string(input int len);
    logic [upc_pkg::ByteW-1:0] b;
    int                        r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) b = 8'($urandom_range(8'h20, 8'h7E));
      else if (r < 65) begin
        case ($urandom_range(0, 5))
          0: b = upc_pkg::CH_SPACE;
          1: b = upc_pkg::CH_PLUS;
          2: b = upc_pkg::CH_EQ;
          3: b = upc_pkg::CH_AMP;
          4: b = upc_pkg::CH_SEMI;
          default: b = upc_pkg::CH_SLASH;
        endcase
      end else b = 8'($urandom_range(0, 255));
      add_byte(b, i == len - 1);
    end
  endtask

  // mostly well-formed escapes and '+', with some noise and cut-short endings
  task automatic add_dec_string(input int len);
    logic [upc_pkg::ByteW-1:0] s[$];
    int                        r;
    while (s.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        s.push_back(upc_pkg::CH_PCT);
        s.push_back(pick_digit());
        s.push_back(pick_digit());
      end else if (r < 55) s.push_back(upc_pkg::CH_PLUS);
      else if (r < 85) s.push_back(8'($urandom_range(8'h20, 8'h7E)));
      else s.push_back(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      s.push_back(upc_pkg::CH_PCT);
    end else if (r == 1) begin
      s.push_back(upc_pkg::CH_PCT);
      s.push_back($urandom_range(0, 1) ? upc_pkg::CH_PLUS : pick_digit());
    end
    foreach (s[i]) add_byte(s[i], i == s.size() - 1);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i) begin : drive
    logic vld_n;
    logic we_n;
    feed_t f;
    vld_n = in_valid_i;
    we_n  = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_fire) vld_n = 1'b0;
      // registers are only written after the block has been quiet for a while
      if (in_valid_i || in_fire || cfg_we_i || expected_bytes.size() != 0) quiet = 0;
      else if (quiet < 1000) quiet++;
      if (!vld_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (feed_q.size() == 0) begin
          feed_done = 1'b1;
        end else if (feed_q[0].is_cfg) begin
          if (quiet >= SettleCyc) begin
            f           = feed_q.pop_front();
            we_n        = 1'b1;
            cfg_index_i <= f.idx;
            cfg_wdata_i <= f.val;
            quiet       = 0;
          end
        end else begin
          f         = feed_q.pop_front();
          in_byte_i <= f.b;
          in_last_i <= f.last;
          vld_n     = 1'b1;
          if (calm_left > 0) begin
            calm_left--;
            gap_left = 0;
          end else begin
            gap_left = next_gap();
            if ($urandom_range(0, 29) == 0) calm_left = 30;
          end
        end
      end
    end
    in_valid_i <= vld_n;
    cfg_we_i   <= we_n;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (open_left > 0) begin
        open_left--;
      end else begin
        stall_left = next_gap();
        open_left  = ($urandom_range(0, 19) == 0) ? 60 : $urandom_range(0, 4);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : watch
    conv_byte_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          upc_pkg::REG_DIRECTION: cfg_dir = cfg_wdata_i[0];
          default:                cfg_kind = cfg_wdata_i;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_codec(in_byte_i, in_last_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got byte %02h", $time,
                   out_byte_o);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_o !== want.b) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.b, out_byte_o);
            mismatches++;
          end
          if (item_done_o !== want.item_done) begin
            $display("%0t: item_done expected %0b, got %0b", $time, want.item_done,
                     item_done_o);
            mismatches++;
          end
          if (string_done_o !== want.string_done) begin
            $display("%0t: string_done expected %0b, got %0b", $time, want.string_done,
                     string_done_o);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    logic                      dir;
    logic [upc_pkg::KindW-1:0] kind;
    int                        len;

    // directed: field extremes, every kind when encoding, value, user and path kinds when decoding, escape corners
    add_cfg(upc_pkg::REG_DIRECTION, upc_pkg::DIR_ENCODE);
    add_cfg(upc_pkg::REG_KIND, upc_pkg::KIND_USER);
    add_byte(8'h00, 1'b0);
    add_byte(8'h3A, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_cfg(upc_pkg::REG_KIND, upc_pkg::KIND_PATH);
    add_byte(upc_pkg::CH_SLASH, 1'b0);
    add_byte(8'h7E, 1'b1);
    add_cfg(upc_pkg::REG_KIND, upc_pkg::KIND_KEY);
    add_byte(upc_pkg::CH_SPACE, 1'b0);
    add_byte(upc_pkg::CH_EQ, 1'b1);
    add_cfg(upc_pkg::REG_KIND, upc_pkg::KIND_VALUE);
    add_byte(upc_pkg::CH_EQ, 1'b0);
    add_byte(upc_pkg::CH_PLUS, 1'b1);
    add_cfg(upc_pkg::REG_DIRECTION, upc_pkg::DIR_DECODE);
    add_byte(upc_pkg::CH_PCT, 1'b0);
    add_byte(8'h34, 1'b0);
    add_byte(8'h66, 1'b0);
    add_byte(upc_pkg::CH_PLUS, 1'b0);
    add_byte(upc_pkg::CH_PCT, 1'b0);   // cut short, '+' still maps to space
    add_byte(upc_pkg::CH_PLUS, 1'b1);
    add_byte(upc_pkg::CH_PCT, 1'b1);   // string ends on the '%'
    add_cfg(upc_pkg::REG_KIND, upc_pkg::KIND_USER);
    add_byte(upc_pkg::CH_PCT, 1'b0);   // non-hex digits go through unvalidated
    add_byte(8'h67, 1'b0);
    add_byte(8'h5A, 1'b0);
    add_byte(upc_pkg::CH_PLUS, 1'b1);
    add_cfg(upc_pkg::REG_KIND, upc_pkg::KIND_PATH);
    add_byte(upc_pkg::CH_PCT, 1'b0);   // left pending across the direction change
    add_cfg(upc_pkg::REG_DIRECTION, upc_pkg::DIR_ENCODE);
    add_byte(8'h80, 1'b1);
    add_cfg(upc_pkg::REG_DIRECTION, upc_pkg::DIR_DECODE);
    add_byte(8'h34, 1'b0);
    add_byte(8'h31, 1'b1);

    // random phases: all eight settings first, then random ones
    for (int p = 0; p < 8 || n_fed < ItemTarget; p++) begin
      if (p < 8) begin
        dir  = p[2];
        kind = p[1:0];
      end else begin
        dir  = 1'($urandom_range(0, 1));
        kind = 2'($urandom_range(0, 3));
      end
      add_cfg(upc_pkg::REG_DIRECTION, {1'b0, dir});
      add_cfg(upc_pkg::REG_KIND, kind);
      repeat ($urandom_range(2, 4)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
        if (dir == upc_pkg::DIR_ENCODE) add_enc_string(len);
        else add_dec_string(len);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(feed_done && expected_bytes.size() == 0)) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
